// ===== src/fida_pkg.sv =====
// Shared types and constants for the FIFO ID allocator.
`default_nettype none

package fida_pkg;

    // ID and count width, and size of the live flag table
    localparam int ID_W      = 8;
    localparam int NUM_FLAGS = 256;

    // Limit register value after reset
    localparam logic [ID_W-1:0] LIMIT_RST = 8'd255;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_QUERY   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOT_LIVE = 2'd3
    } t_status;

    // Free list control: pop head, push tail, rebuild with a new limit
    typedef struct packed {
        logic            reinit;
        logic [ID_W-1:0] reinit_lim;
        logic            pop;
        logic            push;
        logic [ID_W-1:0] push_id;
    } t_fl_ctrl;

    // Live flag control: set on allocate, clear on release
    typedef struct packed {
        logic            reinit;
        logic            set;
        logic [ID_W-1:0] set_id;
        logic            clr;
        logic [ID_W-1:0] clr_id;
    } t_live_ctrl;

endpackage

`default_nettype wire

// ===== src/fida_free_list.sv =====
// Circular free list of IDs with a prefetched head entry.
`default_nettype none

module fida_free_list
    import fida_pkg::*;
#(
    parameter int ID_CAPACITY = 255
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_fl_ctrl        i_ctrl,
    input  wire logic [ID_W-1:0] i_cur_lim,
    output logic      [ID_W-1:0] o_head_id
);

    localparam int PW = (ID_CAPACITY > 1) ? $clog2(ID_CAPACITY) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(ID_CAPACITY - 1);

    logic [ID_W-1:0]        mem [ID_CAPACITY];
    logic [ID_CAPACITY-1:0] r_wvld;
    logic [PW-1:0]          r_head;
    logic [PW-1:0]          r_tail;
    logic [PW-1:0]          n_head;
    logic [PW-1:0]          n_tail;
    logic [PW-1:0]          reinit_tail;
    logic [ID_W-1:0]        r_mem_q;
    logic                   r_hd_vld;
    logic                   r_byp_hit;
    logic [ID_W-1:0]        r_byp_data;
    logic [ID_W-1:0]        init_val;
    logic                   do_push;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == LAST_POS) ? '0 : p + PW'(1);
    endfunction

    // Tail after rebuild: limit modulo capacity, limit never above capacity
    assign reinit_tail = (i_ctrl.reinit_lim == ID_W'(ID_CAPACITY)) ? '0
                                                                    : PW'(i_ctrl.reinit_lim);

    assign do_push = i_ctrl.push && !i_ctrl.reinit;

    // Advance pointers
    always_comb begin
        if (i_ctrl.reinit) begin
            n_head = '0;
            n_tail = reinit_tail;
        end else begin
            n_head = i_ctrl.pop ? ring_next(r_head) : r_head;
            n_tail = do_push ? ring_next(r_tail) : r_tail;
        end
    end

    // Hold pointers, written marks and prefetch control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_wvld    <= '0;
            r_hd_vld  <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_hd_vld  <= !i_ctrl.reinit && r_wvld[n_head];
            r_byp_hit <= do_push && (r_tail == n_head);
            if (i_ctrl.reinit) begin
                r_wvld <= '0;
            end else if (do_push) begin
                r_wvld[r_tail] <= 1'b1;
            end
        end
    end

    // Memory: push at tail, read next head
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_tail] <= i_ctrl.push_id;
        end
        r_mem_q    <= mem[n_head];
        r_byp_data <= i_ctrl.push_id;
    end

    // Unwritten entry p holds p+1 below the limit, else zero
    assign init_val = (ID_W'(r_head) < i_cur_lim) ? ID_W'(r_head) + ID_W'(1) : '0;

    assign o_head_id = r_byp_hit ? r_byp_data : (r_hd_vld ? r_mem_q : init_val);

endmodule

`default_nettype wire

// ===== src/fida_live_tbl.sv =====
// Live flag per ID and the live ID counter.
`default_nettype none

module fida_live_tbl
    import fida_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_live_ctrl      i_ctrl,
    input  wire logic [ID_W-1:0] i_query_id,
    output logic                 o_query_live,
    output logic      [ID_W-1:0] o_total
);

    logic [NUM_FLAGS-1:0] r_flags;
    logic [ID_W-1:0]      r_total;

    // Update flags and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.reinit) begin
            r_flags <= '0;
            r_total <= '0;
        end else begin
            if (i_ctrl.set) begin
                r_flags[i_ctrl.set_id] <= 1'b1;
                r_total <= r_total + ID_W'(1);
            end else if (i_ctrl.clr) begin
                r_flags[i_ctrl.clr_id] <= 1'b0;
                r_total <= r_total - ID_W'(1);
            end
        end
    end

    assign o_query_live = r_flags[i_query_id];
    assign o_total      = r_total;

endmodule

`default_nettype wire

// ===== src/fifo_id_allocator.sv =====
// Top level of the FIFO ID allocator.
//
// Input channel (i_valid / o_stall) carries one request word: i_action
// (allocate, release, query) and i_target_id. Output channel (o_valid /
// i_stall) returns one result word per request: o_status, o_result_id and
// o_live_count. A word moves at an edge where valid is high and stall low.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the ID
// limit; ready is always high, and a write rebuilds the free list as 1..limit
// and clears every live flag in that same cycle.
// The result word appears the cycle after the request is taken. Unless the
// receiver stalls, throughput is one request per cycle, set by the single
// free list memory port pair (one push, one prefetched head read per cycle).
// When the receiver stalls, the result register holds its word and o_stall
// rises, so at most one request waits; a word leaving lets the next one in
// on the same edge. Reset is synchronous and restores the limit to 255, an
// empty output register and a full free list; it needs no clearing pass.
`default_nettype none

module fifo_id_allocator
    import fida_pkg::*;
#(
    parameter int ID_CAPACITY = 255
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [1:0]      i_action,
    input  wire logic [ID_W-1:0] i_target_id,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic      [1:0]      o_status,
    output logic      [ID_W-1:0] o_result_id,
    output logic      [ID_W-1:0] o_live_count,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [ID_W-1:0] i_cfg_data
);

    localparam logic [ID_W-1:0] CAP_ID = ID_W'(ID_CAPACITY);

    logic            r_limit;
    logic [ID_W-1:0] r_lim;
    logic [ID_W-1:0] lim_eff;
    logic [ID_W-1:0] cfg_lim_eff;
    logic            accept;
    logic            cfg_wr;
    logic            busy;
    logic [ID_W-1:0] head_id;
    logic            query_live;
    logic [ID_W-1:0] total;
    logic            in_range;
    t_fl_ctrl        fl_ctrl;
    t_live_ctrl      lv_ctrl;
    t_status         n_status;
    logic [ID_W-1:0] n_rid;
    logic [ID_W-1:0] n_count;
    logic            do_pop;
    logic            do_push;
    logic            r_out_vld;
    t_status         r_out_status;
    logic [ID_W-1:0] r_out_id;
    logic [ID_W-1:0] r_out_count;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_stall     = r_out_vld && i_stall;
    assign accept      = i_valid && !o_stall;
    assign busy        = accept && !cfg_wr;

    // Hold the limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim   <= LIMIT_RST;
            r_limit <= 1'b1;
        end else if (cfg_wr) begin
            r_lim   <= i_cfg_data;
            r_limit <= 1'b1;
        end
    end

    assign lim_eff     = (r_lim < CAP_ID) ? r_lim : CAP_ID;
    assign cfg_lim_eff = (i_cfg_data < CAP_ID) ? i_cfg_data : CAP_ID;
    assign in_range    = (i_target_id != '0) && (i_target_id <= lim_eff) && r_limit;

    // Decide the outcome of the request word
    always_comb begin
        n_status = ST_OK;
        n_rid    = '0;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        unique case (t_action'(i_action))
            ACT_ALLOC: begin
                if (total >= lim_eff) begin
                    n_status = ST_FULL;
                end else begin
                    n_rid  = head_id;
                    do_pop = 1'b1;
                end
            end
            ACT_RELEASE, ACT_QUERY: begin
                if (!in_range) begin
                    n_status = ST_RANGE;
                end else if (!query_live) begin
                    n_status = ST_NOT_LIVE;
                end else begin
                    n_rid   = i_target_id;
                    do_push = (t_action'(i_action) == ACT_RELEASE);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Drive the free list and the live table
    always_comb begin
        fl_ctrl.reinit     = cfg_wr;
        fl_ctrl.reinit_lim = cfg_lim_eff;
        fl_ctrl.pop        = busy && do_pop;
        fl_ctrl.push       = busy && do_push;
        fl_ctrl.push_id    = i_target_id;

        lv_ctrl.reinit = cfg_wr;
        lv_ctrl.set    = busy && do_pop;
        lv_ctrl.set_id = head_id;
        lv_ctrl.clr    = busy && do_push;
        lv_ctrl.clr_id = i_target_id;
    end

    // Count after this word
    always_comb begin
        priority if (do_pop) begin
            n_count = total + ID_W'(1);
        end else if (do_push) begin
            n_count = total - ID_W'(1);
        end else begin
            n_count = total;
        end
    end

    fida_free_list #(
        .ID_CAPACITY (ID_CAPACITY)
    ) u_free_list (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (fl_ctrl),
        .i_cur_lim (lim_eff),
        .o_head_id (head_id)
    );

    fida_live_tbl u_live_tbl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (lv_ctrl),
        .i_query_id   (i_target_id),
        .o_query_live (query_live),
        .o_total      (total)
    );

    // Output register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (accept) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_status <= n_status;
            r_out_id     <= n_rid;
            r_out_count  <= n_count;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_status     = r_out_status;
    assign o_result_id  = r_out_id;
    assign o_live_count = r_out_count;

endmodule

`default_nettype wire

// ===== src/fida_checker.sv =====
// Port-level checks for the FIFO ID allocator, bound to the top level.
`default_nettype none

module fida_checker
    import fida_pkg::*;
(
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_valid,
    input wire logic            o_stall,
    input wire logic            o_valid,
    input wire logic            i_stall,
    input wire logic [1:0]      o_status,
    input wire logic [ID_W-1:0] o_result_id,
    input wire logic [ID_W-1:0] o_live_count
);

    // A stalled result word stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its fields
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable({o_status, o_result_id, o_live_count}))
        else $error("result word changed while stalled");

    // A taken request yields a result word on the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("no result word one cycle after request");

    // Failures report ID zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_result_id == '0))
        else $error("failed request returned a nonzero ID");

    // Reset leaves the output empty
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word present after reset");

endmodule

bind fifo_id_allocator fida_checker u_fida_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_status     (o_status),
    .o_result_id  (o_result_id),
    .o_live_count (o_live_count)
);

`default_nettype wire
